// ----- rtl/core/dtp_pkg.sv -----
// Package for the two-bit DNA base packer and unpacker.
// Holds the queue entry type, the base code tables and the packing helpers.
// Used by every rtl/core module but dtp_checker; depends on nothing.
package dtp_pkg;

	typedef logic [1:0] code_t;
	typedef logic [1:0] hold_cnt_t;

	// Direction register values.
	localparam logic DIR_PACK   = 1'b0;
	localparam logic DIR_UNPACK = 1'b1;

	// Base codes and their ASCII letters.
	localparam code_t CODE_A = 2'd0;
	localparam code_t CODE_C = 2'd1;
	localparam code_t CODE_T = 2'd2;
	localparam code_t CODE_G = 2'd3;

	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_T = 8'h54;
	localparam logic [7:0] CHAR_G = 8'h47;

	// Three held codes means the next base completes a byte.
	localparam hold_cnt_t HOLD_FULL = 2'd3;

	// Command queue between the front and back parts.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// One queued command. A packed byte is a run of one word with
	// cnt_m1 at zero; an unpack command emits cnt_m1 + 1 characters.
	typedef struct packed {
		logic       is_unpack;
		logic [7:0] data;
		logic [1:0] cnt_m1;
		logic       stream_end;
	} q_entry_t;

	function automatic code_t char_to_code(input logic [7:0] ch);
		code_t c;
		case (ch)
			CHAR_C:  c = CODE_C;
			CHAR_T:  c = CODE_T;
			CHAR_G:  c = CODE_G;
			default: c = CODE_A;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] code_to_char(input code_t c);
		logic [7:0] ch;
		unique case (c)
			CODE_A: ch = CHAR_A;
			CODE_C: ch = CHAR_C;
			CODE_T: ch = CHAR_T;
			CODE_G: ch = CHAR_G;
			default: ch = CHAR_A;
		endcase
		return ch;
	endfunction

	// Tail byte for k held codes (newest in bits 1:0). The newest code lands
	// in bits 7:6 and older codes follow below it; unused low bits are zero.
	function automatic logic [7:0] tail_byte(input logic [5:0] codes, input hold_cnt_t k);
		logic [7:0] b;
		case (k)
			2'd1:    b = {codes[1:0], 6'b0};
			2'd2:    b = {codes[1:0], codes[3:2], 4'b0};
			2'd3:    b = {codes[1:0], codes[3:2], codes[5:4], 2'b0};
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/core/dtp_front.sv -----
// Front part of the base packer: accepts input words and turns them into
// queue commands, packing characters into bytes on the way.
// Depends on dtp_pkg.
module dtp_front import dtp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       direction,
	input  logic       item_valid,
	input  logic [7:0] data_in,
	input  logic [2:0] base_count,
	input  logic       stream_end,
	input  logic       q_full,
	output logic       accept,
	output logic       push,
	output q_entry_t   push_entry
);

	logic [5:0] held_codes_q, held_codes_d;
	hold_cnt_t  held_cnt_q, held_cnt_d;
	logic [5:0] codes_n;
	hold_cnt_t  cnt_n;
	code_t      code;

	assign accept = item_valid && !q_full;
	assign code   = char_to_code(data_in);
	assign codes_n = {held_codes_q[3:0], code};
	assign cnt_n   = held_cnt_q + 2'd1;

	always_comb begin
		push         = 1'b0;
		push_entry   = '0;
		held_codes_d = held_codes_q;
		held_cnt_d   = held_cnt_q;
		push_entry.stream_end = stream_end;
		if (accept) begin
			if (direction == DIR_UNPACK) begin
				// Unpack leaves the held codes alone.
				push                 = 1'b1;
				push_entry.is_unpack = 1'b1;
				push_entry.data      = data_in;
				case (base_count)
					3'd0, 3'd1: push_entry.cnt_m1 = 2'd0;
					3'd2:       push_entry.cnt_m1 = 2'd1;
					3'd3:       push_entry.cnt_m1 = 2'd2;
					default:    push_entry.cnt_m1 = 2'd3;
				endcase
			end else if (held_cnt_q == HOLD_FULL) begin
				push            = 1'b1;
				push_entry.data = {held_codes_q, code};
				held_codes_d    = '0;
				held_cnt_d      = '0;
			end else if (stream_end) begin
				push            = 1'b1;
				push_entry.data = tail_byte(codes_n, cnt_n);
				held_codes_d    = '0;
				held_cnt_d      = '0;
			end else begin
				held_codes_d = codes_n;
				held_cnt_d   = cnt_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_codes_q <= '0;
			held_cnt_q   <= '0;
		end else begin
			held_codes_q <= held_codes_d;
			held_cnt_q   <= held_cnt_d;
		end
	end

endmodule

// ----- rtl/core/dtp_queue.sv -----
// Short command queue between the front and back parts of the base packer.
// Depends on dtp_pkg for the entry type and depth.
module dtp_queue import dtp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	input  logic     pop,
	output logic     full,
	output logic     empty,
	output q_entry_t head
);

	localparam logic [Q_PTR_W-1:0] LAST_SLOT = Q_PTR_W'(Q_DEPTH - 1);
	localparam logic [Q_CNT_W-1:0] DEPTH_CNT = Q_CNT_W'(Q_DEPTH);

	q_entry_t            mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0]  cnt_q;
	logic                do_push, do_pop;

	assign full    = (cnt_q == DEPTH_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/dtp_back.sv -----
// Back part of the base packer: walks each queued command one output
// word per cycle unless stalled and holds it in an output register.
// Depends on dtp_pkg.
module dtp_back import dtp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  q_entry_t   head,
	output logic       pop,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] data_out,
	output logic       run_last,
	output logic       stream_done
);

	logic       out_valid_q;
	logic [7:0] data_q;
	logic       last_q, done_q;
	logic [1:0] idx_q;
	logic [1:0] pos;
	logic [2:0] shamt;
	code_t      code;
	logic       load, head_last;

	// A full byte reads bases from the top down; a short byte reads them
	// from its lowest used position upward.
	assign pos       = (head.cnt_m1 == 2'd3) ? idx_q : head.cnt_m1 - idx_q;
	assign shamt     = 3'd6 - {pos, 1'b0};
	assign code      = code_t'(head.data >> shamt);
	assign head_last = (idx_q == head.cnt_m1);
	assign load      = !out_valid_q || !result_stall;
	assign pop       = load && !q_empty && head_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (!q_empty) begin
				idx_q <= head_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			data_q <= head.is_unpack ? code_to_char(code) : head.data;
			last_q <= head_last;
			done_q <= head_last && head.stream_end;
		end
	end

	assign result_valid = out_valid_q;
	assign data_out     = data_q;
	assign run_last     = last_q;
	assign stream_done  = done_q;

endmodule

// ----- rtl/core/dna_two_bit_pack_unpack.sv -----
// Top level of the two-bit DNA base packer and unpacker.
// Instantiates dtp_front, dtp_queue and dtp_back; depends on dtp_pkg.
//
// With direction at 0 the block takes one ASCII base per input word (A, C, T
// and G become codes 0 to 3, anything else becomes 0) and emits a packed byte
// on every fourth base, first base in bits 7:6; a word with stream_end set
// flushes any held bases as a tail byte, newest base in bits 7:6. With
// direction at 1 each input word is a byte plus a base count of 1 to 4, and
// the block emits that many ASCII characters, one per cycle while the output
// is not stalled. Packing takes one input word per cycle while the command
// queue is not full. Unpacking emits 1 to 4 characters per input word (a
// count of 0 acts as 1 and a count above 4 acts as 4); the back part walks
// them while the front keeps accepting words until the two-entry command
// queue is full. A result passes through the command queue into the output
// register if the back part is free. run_last marks the last word caused
// by an input word, and stream_done the last word of the stream. The
// direction register lives at address 0 of the APB port and may only be
// written while idle; changing it does not clear bases held for packing.
module dna_two_bit_pack_unpack import dtp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input channel.
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  data_in,
	input  logic [2:0]  base_count,
	input  logic        stream_end,
	// Output channel.
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  data_out,
	output logic        run_last,
	output logic        stream_done
);

	logic     direction_q;
	logic     cfg_write;
	logic     accept, push, pop, q_full, q_empty;
	q_entry_t push_entry, head;

	// Only one register exists, so every address within the port's range
	// maps to the direction register.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[1:0] == 2'b00 || paddr != 2'b00);
	assign prdata    = {31'b0, direction_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_PACK;
		end else if (cfg_write) begin
			direction_q <= pwdata[0];
		end
	end

	// The input is held off only while the command queue is full.
	assign item_stall = q_full;

	dtp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.direction  (direction_q),
		.item_valid (item_valid),
		.data_in    (data_in),
		.base_count (base_count),
		.stream_end (stream_end),
		.q_full     (q_full),
		.accept     (accept),
		.push       (push),
		.push_entry (push_entry)
	);

	dtp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push && accept),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.empty      (q_empty),
		.head       (head)
	);

	dtp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.data_out     (data_out),
		.run_last     (run_last),
		.stream_done  (stream_done)
	);

endmodule

// ----- rtl/core/dtp_checker.sv -----
// Port-level checks for the two-bit DNA base packer and unpacker, with the
// bind that attaches them to dna_two_bit_pack_unpack. No package needed.
module dtp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input logic       result_valid,
	input logic       result_stall,
	input logic [7:0] data_out,
	input logic       run_last,
	input logic       stream_done
);

	// A stalled output word holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(data_out)
			&& $stable(run_last) && $stable(stream_done))
		else $error("output word changed while stalled");

	// The end of the stream is always the end of a run.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && stream_done |-> run_last)
		else $error("stream_done without run_last");

	// The rest of a run is already queued, so it follows without a gap.
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !run_last && !result_stall |=> result_valid)
		else $error("gap inside an output run");

	// The input can only be held off after a word has been taken in.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(item_stall) |-> $past(item_valid && !item_stall))
		else $error("input stall rose without an accepted word");

endmodule

bind dna_two_bit_pack_unpack dtp_checker u_dtp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.data_out     (data_out),
	.run_last     (run_last),
	.stream_done  (stream_done)
);
